// File: rtl/camera_target_frame_parser_top_assert.svh
// ----------------------------------------------------------------------------
// Camera target frame parser: assertion macros
// Shared check forms for the frame parser, clocked on clock, held off in reset.
// ----------------------------------------------------------------------------
`ifndef CAMERA_TARGET_FRAME_PARSER_TOP_ASSERT_SVH
`define CAMERA_TARGET_FRAME_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define CTFP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ctfp: same-cycle check failed");

// next-cycle implication
`define CTFP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ctfp: next-cycle check failed");

`endif

// File: rtl/ctfp_pkg.sv
// ----------------------------------------------------------------------------
// Camera target frame parser package
// Frame constants, parse phase and target kind codes, shared structs.
// ----------------------------------------------------------------------------
package ctfp_pkg;

   localparam logic [7:0] HDR_FIRST  = 8'h2C;
   localparam logic [7:0] HDR_SECOND = 8'h04;
   localparam logic [7:0] TAIL_BYTE  = 8'h5B;
   localparam logic [7:0] LASER_NONE = 8'd125;

   // frame positions
   localparam logic [2:0] POS_NUMBER = 3'd2;
   localparam logic [2:0] POS_X      = 3'd4;
   localparam logic [2:0] POS_Y      = 3'd6;
   localparam logic [2:0] POS_LAST   = 3'd7;

   // target numbers with a meaning of their own
   localparam logic [7:0] NUM_RECT_MAX = 8'd3;
   localparam logic [7:0] NUM_LASER0   = 8'd4;
   localparam logic [7:0] NUM_LASER1   = 8'd5;
   localparam logic [7:0] NUM_ANGLE    = 8'd7;

   typedef enum logic [1:0] {
      PHASE_HUNT,
      PHASE_SECOND,
      PHASE_PAYLOAD,
      PHASE_TAIL
   } phase_type;

   typedef enum logic [2:0] {
      KIND_RECT,
      KIND_LASER0,
      KIND_LASER1,
      KIND_ANGLE,
      KIND_MISSING,
      KIND_UNUSED
   } kind_type;

   typedef struct packed {
      logic        [7:0] frame_number;
      logic signed [7:0] coord_x;
      logic signed [7:0] coord_y;
      kind_type          target_kind;
      logic        [1:0] corner_slot;
   } result_type;

   typedef struct packed {
      phase_type  phase;
      logic [2:0] count;
   } status_type;

endpackage

// File: rtl/ctfp_if.sv
// ----------------------------------------------------------------------------
// Camera target frame parser channels
// Valid/ready item channels for received bytes and decoded targets.
// ----------------------------------------------------------------------------
interface ctfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface ctfp_rsp_if;
   logic              valid;
   logic              ready;
   logic        [7:0] frame_number;
   logic signed [7:0] coord_x;
   logic signed [7:0] coord_y;
   logic        [2:0] target_kind;
   logic        [1:0] corner_slot;

   modport source (output valid, output frame_number, output coord_x, output coord_y,
                   output target_kind, output corner_slot, input ready);
   modport sink   (input valid, input frame_number, input coord_x, input coord_y,
                   input target_kind, input corner_slot, output ready);
endinterface

// File: rtl/ctfp_parser.sv
// ----------------------------------------------------------------------------
// Camera target frame parser: byte parser
// Phase tracking, payload capture and target classification per byte.
// ----------------------------------------------------------------------------
module ctfp_parser
   import ctfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   output logic       emit,
   output result_type result,
   output status_type status
);

   phase_type  phase_ff, phase_in;
   logic [2:0] count_ff, count_in;
   logic [7:0] number_ff, number_in;
   logic [7:0] x_ff, x_in;
   logic [7:0] y_ff, y_in;
   logic [2:0] count_inc;

   assign count_inc = count_ff + 3'd1;

   // next state
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      number_in = number_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      case (phase_ff)
         PHASE_HUNT: begin
            if (data_byte == HDR_FIRST) begin
               phase_in = PHASE_SECOND;
               count_in = count_inc;
            end else begin
               count_in  = '0;
               number_in = '0;
               x_in      = '0;
               y_in      = '0;
            end
         end
         PHASE_SECOND: begin
            if (data_byte == HDR_SECOND) begin
               phase_in = PHASE_PAYLOAD;
               count_in = count_inc;
            end else begin
               // consumed, never taken as a fresh header
               phase_in  = PHASE_HUNT;
               count_in  = '0;
               number_in = '0;
               x_in      = '0;
               y_in      = '0;
            end
         end
         PHASE_PAYLOAD: begin
            if (count_ff == POS_NUMBER) number_in = data_byte;
            if (count_ff == POS_X)      x_in      = data_byte;
            if (count_ff == POS_Y)      y_in      = data_byte;
            count_in = count_inc;
            if (count_inc == POS_LAST) phase_in = PHASE_TAIL;
         end
         PHASE_TAIL: begin
            phase_in = PHASE_HUNT;
            count_in = '0;
            if (data_byte != TAIL_BYTE) begin
               number_in = '0;
               x_in      = '0;
               y_in      = '0;
            end
         end
         default: begin
            phase_in = PHASE_HUNT;
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_HUNT;
         count_ff  <= '0;
         number_ff <= '0;
         x_ff      <= '0;
         y_ff      <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         number_ff <= number_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
      end
   end

   // result on a good tail
   assign emit = accept && (phase_ff == PHASE_TAIL) && (data_byte == TAIL_BYTE);

   always_comb begin
      result.frame_number = number_ff;
      result.coord_x      = x_ff;
      result.coord_y      = y_ff;
      result.corner_slot  = '0;
      if (number_ff <= NUM_RECT_MAX) begin
         result.target_kind = KIND_RECT;
         result.corner_slot = number_ff[1:0];
      end else if (number_ff == NUM_LASER0) begin
         result.target_kind = (x_ff == LASER_NONE) ? KIND_MISSING : KIND_LASER0;
      end else if (number_ff == NUM_LASER1) begin
         result.target_kind = (x_ff == LASER_NONE) ? KIND_MISSING : KIND_LASER1;
      end else if (number_ff == NUM_ANGLE) begin
         result.target_kind = KIND_ANGLE;
      end else begin
         result.target_kind = KIND_UNUSED;
      end
   end

   assign status.phase = phase_ff;
   assign status.count = count_ff;

endmodule

// File: rtl/camera_target_frame_parser_top.sv
// ----------------------------------------------------------------------------
// Camera target frame parser
// Finds eight-byte target frames in the camera byte stream, one item per byte.
// ----------------------------------------------------------------------------
// A good tail byte's result is registered in the output register, or in the skid.
// Throughput: one byte item per cycle unless stalled; the phase updates on accept.
// A two-deep result buffer (output register plus skid) keeps req_ch open while a
// result waits; req_ch stalls only when both entries are full.
// Reset (synchronous, active high): parser back to hunting, held bytes cleared,
// result buffer emptied.
// ----------------------------------------------------------------------------
`include "camera_target_frame_parser_top_assert.svh"

module camera_target_frame_parser_top
   import ctfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ctfp_req_if.sink    req_ch,
   ctfp_rsp_if.source  rsp_ch
);

   logic       req_accept;
   logic       rsp_pop;
   logic       emit;
   logic       push;
   result_type result;
   status_type status;

   // result buffer: head is the output register, skid holds a second result
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;

   // Only the skid decides backpressure, so a full output register never
   // holds up the byte stream by itself.
   assign req_ch.ready = !skid_valid_ff;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign rsp_pop      = rsp_ch.valid && rsp_ch.ready;

   ctfp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .data_byte (req_ch.data_byte),
      .emit      (emit),
      .result    (result),
      .status    (status)
   );

   assign push = emit;

   // buffer control
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         // input is stalled here, so no push
         if (rsp_pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (out_valid_ff) begin
         if (push && rsp_pop) begin
            out_in = result;
         end else if (push) begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end else if (rsp_pop) begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         out_in       = result;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.frame_number = out_ff.frame_number;
   assign rsp_ch.coord_x      = out_ff.coord_x;
   assign rsp_ch.coord_y      = out_ff.coord_y;
   assign rsp_ch.target_kind  = out_ff.target_kind;
   assign rsp_ch.corner_slot  = out_ff.corner_slot;

   // checks
   `CTFP_ASSERT_NOW(a_skid_behind_out, skid_valid_ff, out_valid_ff)
   `CTFP_ASSERT_NOW(a_no_push_when_full, push, !skid_valid_ff)
   `CTFP_ASSERT_NOW(a_hunt_count_zero, status.phase == PHASE_HUNT, status.count == 3'd0)
   `CTFP_ASSERT_NEXT(a_tail_back_to_hunt, push, status.phase == PHASE_HUNT && out_valid_ff)

endmodule
